FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled during reset
`define MPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define MPR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/mpr_pkg.sv
// Constants and types for the MSB prediction recovery unit
`timescale 1ns / 1ps

package mpr_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = HEIGHT_REG_W;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(512);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(512);

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   // sum of three neighbors, and floor(x/3) as (x*683)>>11, exact for x < 2047
   localparam int SUM_W       = PIX_W + 2;
   localparam int DIV3_MUL    = 683;
   localparam int DIV3_MUL_W  = 10;
   localparam int DIV3_SHIFT  = 11;
   localparam int PROD_W      = SUM_W + DIV3_MUL_W;

   localparam logic [PIX_W-1:0] MSB_MASK = PIX_W'(1 << 7);

   // output queue
   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [PIX_W-1:0] pixel_type;

endpackage

FILE: rtl/mpr_if.sv
// Handshake channels of the MSB prediction recovery unit
`timescale 1ns / 1ps

interface mpr_req_if;
   import mpr_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mpr_rsp_if;
   import mpr_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_out;
   logic      frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface mpr_csr_if;
   import mpr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/msb_prediction_recovery_unit.sv
// MSB prediction recovery: line buffer in one RAM, neighbor regs, output queue
// An accepted word is registered in the compute stage with its RAM read, then in the output queue that drives rsp.
// Throughput: one word per cycle while the output queue has room; the line buffer RAM can be read and written together.
// A 3-entry output queue lets input continue while rsp is stalled.
// Reset clears counters, neighbor regs and queue, and sets width and height to 512.
// The line buffer is not cleared; a row is written before it is read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msb_prediction_recovery_unit
   import mpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mpr_req_if.sink     req_ch,
   mpr_rsp_if.source   rsp_ch,
   mpr_csr_if.sink     csr_ch
);

   // configuration
   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        width_m1;
   logic [ROW_W-1:0]        height_m1;

   // position of next word
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             row_end, frame_end, req_accept;

   // line buffer
   pixel_type row_mem [MAX_WIDTH];
   pixel_type rd_data_ff;

   // compute stage
   logic             s1_valid_ff;
   pixel_type        s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_pass_ff, s1_last_ff;
   logic             fwd_ff;
   pixel_type        fwd_data_ff;
   pixel_type        left_ff, left_in, upleft_ff, upleft_in;

   pixel_type           upper, flipped, pred, result, d_keep, d_flip;
   logic [SUM_W-1:0]    nsum;
   logic [PROD_W-1:0]   prod;

   // output queue
   pixel_type              q_pix_ff  [FIFO_DEPTH];
   logic                   q_last_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   pop;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_IMAGE_WIDTH:  width_in  = csr_ch.data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // effective size minus one: zero counts as one, large values saturate
   always_comb begin
      if (width_ff == '0) begin
         width_m1 = '0;
      end else if (width_ff > WIDTH_REG_W'(MAX_WIDTH)) begin
         width_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_m1 = COL_W'(width_ff - WIDTH_REG_W'(1));
      end
      if (height_ff == '0) begin
         height_m1 = '0;
      end else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         height_m1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         height_m1 = ROW_W'(height_ff - HEIGHT_REG_W'(1));
      end
   end

   // room for this word and the one in the compute stage
   assign req_ch.ready = ({1'b0, count_ff} + (FIFO_CNT_W + 1)'(s1_valid_ff))
                         < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign row_end   = col_ff >= width_m1;
   assign frame_end = row_end && (row_ff >= height_m1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // compute: prediction from left, upper, upper-left
   always_comb begin
      upper   = fwd_ff ? fwd_data_ff : rd_data_ff;
      flipped = s1_pix_ff ^ MSB_MASK;
      nsum    = SUM_W'(left_ff) + SUM_W'(upper) + SUM_W'(upleft_ff);
      prod    = PROD_W'(nsum) * PROD_W'(DIV3_MUL);
      pred    = prod[DIV3_SHIFT +: PIX_W];
      d_keep  = (pred > s1_pix_ff) ? pred - s1_pix_ff : s1_pix_ff - pred;
      d_flip  = (pred > flipped) ? pred - flipped : flipped - pred;
      result  = (s1_pass_ff || (d_keep < d_flip)) ? s1_pix_ff : flipped;
      left_in   = s1_valid_ff ? result : left_ff;
      upleft_in = s1_valid_ff ? upper : upleft_ff;
   end

   // line buffer RAM: read for the new word, write back the finished one
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         row_mem[s1_col_ff] <= result;
      end
      if (req_accept) begin
         rd_data_ff <= row_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         left_ff     <= '0;
         upleft_ff   <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= req_accept;
         // same entry written this cycle: RAM returns stale data, bypass it
         fwd_ff      <= req_accept && s1_valid_ff && (s1_col_ff == col_ff);
         left_ff     <= left_in;
         upleft_ff   <= upleft_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff  <= req_ch.pixel_in;
         s1_col_ff  <= col_ff;
         s1_pass_ff <= (row_ff == '0) || (col_ff == '0);
         s1_last_ff <= frame_end;
      end
      fwd_data_ff <= result;
   end

   // output queue
   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign count_in = count_ff + FIFO_CNT_W'(s1_valid_ff) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (s1_valid_ff) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_pix_ff[wr_ptr_ff]  <= result;
         q_last_ff[wr_ptr_ff] <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = count_ff != '0;
   assign rsp_ch.pixel_out  = q_pix_ff[rd_ptr_ff];
   assign rsp_ch.frame_last = q_last_ff[rd_ptr_ff];

   `MPR_ASSERT(a_queue_room, clock, reset,
      !s1_valid_ff || (count_ff < FIFO_CNT_W'(FIFO_DEPTH)), "queue full on push")
   `MPR_ASSERT(a_fwd_needs_s1, clock, reset,
      !fwd_ff || s1_valid_ff, "bypass without word in compute stage")
   `MPR_ASSERT(a_col0_pass, clock, reset,
      !(s1_valid_ff && (s1_col_ff == '0)) || s1_pass_ff, "first column not passed through")
   `MPR_ASSERT_NEXT(a_accept_to_s1, clock, reset,
      req_accept, s1_valid_ff, "accepted word lost before compute")

endmodule
